>>> hdl/dlss_pkg.sv
// Shared types and constants for the dual list sort/stat engine.
// No dependencies.
package dlss_pkg;

	localparam int VAL_W      = 32;
	localparam int CNT_OUT_W  = 7;
	localparam int SUM_W      = 38;
	localparam int DVD_W      = SUM_W + 8;
	localparam int MEAN_W     = 40;
	localparam int STAT_W     = 3;

	localparam logic [2:0] REQ_APPEND = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_SHOW   = 3'd2;
	localparam logic [2:0] REQ_COUNT  = 3'd3;
	localparam logic [2:0] REQ_MEAN   = 3'd4;

	localparam logic [1:0] ORD_ASC    = 2'd0;
	localparam logic [1:0] ORD_DESC   = 2'd1;
	localparam logic [1:0] ORD_INSERT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_REMOVED = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTF    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_ELEM    = 3'd4;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd5;
	localparam logic [STAT_W-1:0] STAT_COUNT   = 3'd6;
	localparam logic [STAT_W-1:0] STAT_MEAN    = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SHIFT, S_CPY, S_SORT, S_STAIL,
		S_ORD, S_OLD, S_OWAIT, S_SUM, S_DIV, S_RESP
	} state_t;

endpackage

>>> hdl/dlss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlss_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/dlss_div.sv
// Restoring signed-by-unsigned divider, one quotient bit per cycle.
// Depends on dlss_pkg.
module dlss_div #(
	parameter int DV_W = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [dlss_pkg::DVD_W-1:0] dividend,
	input  logic [DV_W-1:0]                   divisor,
	output logic                              done,
	output logic signed [dlss_pkg::MEAN_W-1:0] quotient
);

	localparam int DW = dlss_pkg::DVD_W;
	localparam int SW = $clog2(DW);

	logic          busy_q, done_q, neg_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] mag_q, q_full;
	logic [DV_W-1:0] rem_q, dvs_q, rem_n;
	logic [DV_W:0] trial;
	logic          ge;

	assign trial = {rem_q, mag_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (step_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= dividend[DW-1];
			mag_q  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			rem_q  <= '0;
			dvs_q  <= divisor;
			step_q <= SW'(DW - 1);
		end else if (busy_q) begin
			mag_q  <= {mag_q[DW-2:0], ge};
			rem_q  <= rem_n;
			step_q <= step_q - 1'b1;
		end
	end

	assign q_full   = neg_q ? DW'(-mag_q) : mag_q;
	assign quotient = q_full[dlss_pkg::MEAN_W-1:0];
	assign done     = done_q;

endmodule

>>> hdl/dual_list_sort_stat_engine.sv
// Dual list engine: append/remove/show(sorted or in insertion order)/count/mean over two bounded lists.
// One request at a time: s_tready is high only when idle and the last word is taken.
// The bubble sort of a show runs through the single read port of the scratch RAM.
// Async active-low reset empties both lists; RAM contents are not cleared.
module dual_list_sort_stat_engine #(
	parameter int LIST_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] operand_value
	input  logic [5:0]  s_tuser,  // [2:0] req_type, [3] list_sel, [5:4] sort_order
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [31:0] element_value, [38:32] element_count,
	                              // [78:39] mean_q8, [79] zero pad
	output logic [2:0]  m_tuser,  // [2:0] status
	output logic        m_tlast   // last word of the request
);

	localparam int CW   = $clog2(LIST_CAPACITY + 1);
	localparam int IW   = $clog2(LIST_CAPACITY);
	localparam int ST_D = 2 * (2 ** IW);
	localparam int VW   = dlss_pkg::VAL_W;

	dlss_pkg::state_t state_q, state_n;

	// control
	logic [CW-1:0] cnt_q [2];
	logic          o_valid_q, rv_s1;

	// payload
	logic          sel_q;
	logic [VW-1:0] opv_q;
	logic [1:0]    ord_q;
	logic [CW-1:0] n_q, m_q, rd_idx_q, ridx_s1;
	logic signed [VW-1:0] cur_q;
	logic signed [dlss_pkg::SUM_W-1:0] sum_q;
	logic [dlss_pkg::STAT_W-1:0]   o_status_q;
	logic [VW-1:0]                 o_value_q;
	logic [dlss_pkg::CNT_OUT_W-1:0] o_count_q;
	logic [dlss_pkg::MEAN_W-1:0]   o_mean_q;
	logic                          o_last_q;

	// input decode
	logic          acc;
	logic [2:0]    in_req;
	logic          in_sel;
	logic [CW-1:0] n_in;

	assign acc    = s_tvalid && s_tready;
	assign in_req = s_tuser[2:0];
	assign in_sel = s_tuser[3];
	assign n_in   = cnt_q[in_sel];

	// RAM ports
	logic              st_we, sc_we;
	logic [IW:0]       st_waddr, st_raddr;
	logic [IW-1:0]     sc_waddr, sc_raddr;
	logic [VW-1:0]     st_wdata, sc_wdata, st_rdata, sc_rdata;
	logic              issue, hit, swp, done_rd, div_start, div_done;
	logic [CW-1:0]     lim;
	logic signed [dlss_pkg::MEAN_W-1:0] div_q;

	assign lim     = (state_q == dlss_pkg::S_SORT) ? m_q : n_q;
	assign done_rd = (rd_idx_q == lim) && !rv_s1;
	assign hit     = rv_s1 && (st_rdata == opv_q);
	// bubble compare of the carried word against the arriving one
	assign swp     = rv_s1 && (ridx_s1 != '0) &&
	                 (((ord_q == dlss_pkg::ORD_ASC) && (cur_q > signed'(sc_rdata))) ||
	                  ((ord_q == dlss_pkg::ORD_DESC) && (cur_q < signed'(sc_rdata))));

	dlss_ram #(.W(VW), .D(ST_D)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	dlss_ram #(.W(VW), .D(2 ** IW)) u_scratch (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.raddr(sc_raddr), .rdata(sc_rdata)
	);

	dlss_div #(.DV_W(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({sum_q, 8'b0}), .divisor(n_q),
		.done(div_done), .quotient(div_q)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			dlss_pkg::S_IDLE: begin
				if (acc) begin
					case (in_req)
						dlss_pkg::REQ_APPEND: state_n = dlss_pkg::S_RESP;
						dlss_pkg::REQ_COUNT:  state_n = dlss_pkg::S_RESP;
						dlss_pkg::REQ_REMOVE: state_n = dlss_pkg::S_SCAN;
						dlss_pkg::REQ_SHOW:
							state_n = (n_in == '0) ? dlss_pkg::S_RESP : dlss_pkg::S_CPY;
						dlss_pkg::REQ_MEAN:   state_n = dlss_pkg::S_SUM;
						default:              state_n = dlss_pkg::S_IDLE;
					endcase
				end
			end
			dlss_pkg::S_SCAN: begin
				if (hit) state_n = dlss_pkg::S_SHIFT;
				else if (done_rd) state_n = dlss_pkg::S_RESP;
			end
			dlss_pkg::S_SHIFT: if (done_rd) state_n = dlss_pkg::S_RESP;
			dlss_pkg::S_CPY: begin
				if (done_rd) begin
					state_n = ((n_q >= CW'(2)) &&
					          (ord_q inside {dlss_pkg::ORD_ASC, dlss_pkg::ORD_DESC})) ?
					          dlss_pkg::S_SORT : dlss_pkg::S_ORD;
				end
			end
			dlss_pkg::S_SORT:  if (done_rd) state_n = dlss_pkg::S_STAIL;
			dlss_pkg::S_STAIL:
				state_n = (m_q > CW'(2)) ? dlss_pkg::S_SORT : dlss_pkg::S_ORD;
			dlss_pkg::S_ORD:   state_n = dlss_pkg::S_OLD;
			dlss_pkg::S_OLD:   state_n = dlss_pkg::S_OWAIT;
			dlss_pkg::S_OWAIT: begin
				if (m_tready) state_n = o_last_q ? dlss_pkg::S_IDLE : dlss_pkg::S_ORD;
			end
			dlss_pkg::S_SUM: begin
				if (done_rd) state_n = (n_q == '0) ? dlss_pkg::S_RESP : dlss_pkg::S_DIV;
			end
			dlss_pkg::S_DIV:   if (div_done) state_n = dlss_pkg::S_RESP;
			dlss_pkg::S_RESP:  if (m_tready) state_n = dlss_pkg::S_IDLE;
			default:           state_n = dlss_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		s_tready  = (state_q == dlss_pkg::S_IDLE);
		issue     = 1'b0;
		st_we     = 1'b0;
		st_waddr  = {in_sel, n_in[IW-1:0]};
		st_wdata  = s_tdata;
		st_raddr  = {sel_q, rd_idx_q[IW-1:0]};
		sc_we     = 1'b0;
		sc_waddr  = ridx_s1[IW-1:0];
		sc_wdata  = st_rdata;
		sc_raddr  = rd_idx_q[IW-1:0];
		div_start = 1'b0;
		case (state_q)
			dlss_pkg::S_IDLE: begin
				st_we = acc && (in_req == dlss_pkg::REQ_APPEND) &&
				        (n_in < CW'(LIST_CAPACITY));
			end
			dlss_pkg::S_SCAN:  issue = (rd_idx_q < n_q) && !hit;
			dlss_pkg::S_SHIFT: begin
				issue    = rd_idx_q < n_q;
				st_we    = rv_s1;
				st_waddr = {sel_q, IW'(ridx_s1 - 1'b1)};
				st_wdata = st_rdata;
			end
			dlss_pkg::S_CPY: begin
				issue = rd_idx_q < n_q;
				sc_we = rv_s1;
			end
			dlss_pkg::S_SORT: begin
				issue    = rd_idx_q < m_q;
				sc_we    = rv_s1 && (ridx_s1 != '0);
				sc_waddr = IW'(ridx_s1 - 1'b1);
				sc_wdata = swp ? sc_rdata : cur_q;
			end
			dlss_pkg::S_STAIL: begin
				sc_we    = 1'b1;
				sc_waddr = IW'(m_q - 1'b1);
				sc_wdata = cur_q;
			end
			dlss_pkg::S_ORD:   issue = 1'b1;
			dlss_pkg::S_SUM:   begin
				issue     = rd_idx_q < n_q;
				div_start = done_rd && (n_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlss_pkg::S_IDLE;
			o_valid_q <= 1'b0;
			rv_s1     <= 1'b0;
			cnt_q[0]  <= '0;
			cnt_q[1]  <= '0;
		end else begin
			state_q <= state_n;
			rv_s1   <= issue && (state_q != dlss_pkg::S_ORD);
			if (m_tvalid && m_tready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				dlss_pkg::S_IDLE: begin
					if (acc && ((in_req inside {dlss_pkg::REQ_APPEND, dlss_pkg::REQ_COUNT}) ||
					            (in_req == dlss_pkg::REQ_SHOW && n_in == '0))) begin
						o_valid_q <= 1'b1;
					end
					if (st_we) cnt_q[in_sel] <= n_in + 1'b1;
				end
				dlss_pkg::S_SCAN:  if (!hit && done_rd) o_valid_q <= 1'b1;
				dlss_pkg::S_SHIFT: begin
					if (done_rd) begin
						o_valid_q    <= 1'b1;
						cnt_q[sel_q] <= n_q - 1'b1;
					end
				end
				dlss_pkg::S_OLD:   o_valid_q <= 1'b1;
				dlss_pkg::S_SUM:   if (done_rd && n_q == '0) o_valid_q <= 1'b1;
				dlss_pkg::S_DIV:   if (div_done) o_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) rd_idx_q <= rd_idx_q + 1'b1;
		ridx_s1 <= rd_idx_q;
		case (state_q)
			dlss_pkg::S_IDLE: begin
				if (acc) begin
					sel_q    <= in_sel;
					opv_q    <= s_tdata;
					ord_q    <= s_tuser[5:4];
					n_q      <= n_in;
					m_q      <= n_in;
					rd_idx_q <= '0;
					sum_q    <= '0;
					o_value_q <= s_tdata;
					o_mean_q  <= '0;
					o_last_q  <= 1'b1;
					o_count_q <= dlss_pkg::CNT_OUT_W'(n_in);
					case (in_req)
						dlss_pkg::REQ_APPEND: begin
							if (n_in < CW'(LIST_CAPACITY)) begin
								o_status_q <= dlss_pkg::STAT_ADDED;
								o_count_q  <= dlss_pkg::CNT_OUT_W'(n_in + 1'b1);
							end else begin
								o_status_q <= dlss_pkg::STAT_FULL;
							end
						end
						// remove echoes the operand in either outcome
						dlss_pkg::REQ_REMOVE: o_status_q <= dlss_pkg::STAT_NOTF;
						dlss_pkg::REQ_COUNT: begin
							o_status_q <= dlss_pkg::STAT_COUNT;
							o_value_q  <= '0;
						end
						default: begin
							o_status_q <= dlss_pkg::STAT_EMPTY;
							o_value_q  <= '0;
						end
					endcase
				end
			end
			dlss_pkg::S_SCAN: begin
				if (hit) begin
					rd_idx_q <= ridx_s1 + 1'b1;
				end else if (done_rd) begin
					o_status_q <= dlss_pkg::STAT_NOTF;
				end
			end
			dlss_pkg::S_SHIFT: begin
				if (done_rd) begin
					o_status_q <= dlss_pkg::STAT_REMOVED;
					o_count_q  <= dlss_pkg::CNT_OUT_W'(n_q - 1'b1);
				end
			end
			dlss_pkg::S_CPY:   if (done_rd) rd_idx_q <= '0;
			dlss_pkg::S_SORT: begin
				if (rv_s1 && (ridx_s1 == '0)) cur_q <= sc_rdata;
				else if (rv_s1 && !swp) cur_q <= sc_rdata;
			end
			dlss_pkg::S_STAIL: begin
				m_q      <= m_q - 1'b1;
				rd_idx_q <= '0;
			end
			dlss_pkg::S_OLD: begin
				o_status_q <= dlss_pkg::STAT_ELEM;
				o_value_q  <= sc_rdata;
				o_last_q   <= (rd_idx_q == n_q);
			end
			dlss_pkg::S_SUM: begin
				o_status_q <= dlss_pkg::STAT_MEAN;
				o_value_q  <= '0;
				if (rv_s1) begin
					sum_q <= sum_q + {{(dlss_pkg::SUM_W - VW){st_rdata[VW-1]}}, st_rdata};
				end
			end
			dlss_pkg::S_DIV:   if (div_done) o_mean_q <= div_q;
			default: ;
		endcase
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {1'b0, o_mean_q, o_count_q, o_value_q};
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;

	// a new request is never taken while a word is still pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("request taken with word pending");

	a_cnt_a: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(LIST_CAPACITY)) else $error("list A count over capacity");

	a_cnt_b: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[1] <= CW'(LIST_CAPACITY)) else $error("list B count over capacity");

	// only element words of a listing may be non-final
	a_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == dlss_pkg::STAT_ELEM))
		else $error("non-final word that is not an element");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == dlss_pkg::S_DIV)) else $error("stray divider done");

endmodule

>>> bench/dual_list_sort_stat_checker.sv
`timescale 1ns / 100ps
// Checker for the dual list engine: watches both stream channels, keeps its
// own copy of the two lists and compares every output word. Depends on dlss_pkg.
module dual_list_sort_stat_checker #(
	parameter int LIST_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [5:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic [6:0]         count;
		logic signed [39:0] mean;
		logic               last;
	} word_t;

	logic signed [31:0] lists [2][LIST_CAPACITY];
	int                 lens [2];
	word_t              expected_words [$];

	assign pending = expected_words.size();

	function automatic word_t mk(logic [2:0] st, logic signed [31:0] v, int n,
		logic signed [39:0] m, logic l);
		word_t w;
		w.status = st; w.value = v; w.count = n[6:0]; w.mean = m; w.last = l;
		return w;
	endfunction

	task automatic predict_request(logic [2:0] req, int sel, logic signed [31:0] opv,
		logic [1:0] ord);
		logic signed [31:0] tmp [LIST_CAPACITY];
		logic signed [31:0] t;
		longint sum;
		int n, idx;
		n = lens[sel];
		idx = -1;
		case (req)
			dlss_pkg::REQ_APPEND: begin
				if (n >= LIST_CAPACITY)
					expected_words.push_back(mk(dlss_pkg::STAT_FULL, opv, n, 40'sd0, 1'b1));
				else begin
					lists[sel][n] = opv;
					lens[sel] = n + 1;
					expected_words.push_back(mk(dlss_pkg::STAT_ADDED, opv, n + 1, 40'sd0, 1'b1));
				end
			end
			dlss_pkg::REQ_REMOVE: begin
				for (int i = 0; i < n; i++)
					if (idx < 0 && lists[sel][i] == opv) idx = i;
				if (idx < 0)
					expected_words.push_back(mk(dlss_pkg::STAT_NOTF, opv, n, 40'sd0, 1'b1));
				else begin
					for (int j = idx; j + 1 < n; j++) lists[sel][j] = lists[sel][j + 1];
					lens[sel] = n - 1;
					expected_words.push_back(mk(dlss_pkg::STAT_REMOVED, opv, n - 1, 40'sd0,
						1'b1));
				end
			end
			dlss_pkg::REQ_SHOW: begin
				if (n == 0)
					expected_words.push_back(mk(dlss_pkg::STAT_EMPTY, 32'sd0, 0, 40'sd0, 1'b1));
				else begin
					for (int i = 0; i < n; i++) tmp[i] = lists[sel][i];
					for (int i = 0; i + 1 < n; i++)
						for (int j = 0; j + 1 < n - i; j++)
							if ((ord == dlss_pkg::ORD_ASC && tmp[j] > tmp[j + 1]) ||
							    (ord == dlss_pkg::ORD_DESC && tmp[j] < tmp[j + 1])) begin
								t = tmp[j]; tmp[j] = tmp[j + 1]; tmp[j + 1] = t;
							end
					for (int i = 0; i < n; i++)
						expected_words.push_back(mk(dlss_pkg::STAT_ELEM, tmp[i], n, 40'sd0,
							i + 1 == n));
				end
			end
			dlss_pkg::REQ_COUNT:
				expected_words.push_back(mk(dlss_pkg::STAT_COUNT, 32'sd0, n, 40'sd0, 1'b1));
			dlss_pkg::REQ_MEAN: begin
				sum = 0;
				for (int i = 0; i < n; i++) sum += longint'(lists[sel][i]);
				// longint division truncates toward zero
				expected_words.push_back(mk(dlss_pkg::STAT_MEAN, 32'sd0, n,
					n > 0 ? 40'((sum * 256) / n) : 40'sd0, 1'b1));
			end
			default: ;  // unused request codes give no word
		endcase
	endtask

	word_t got, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens[0] = 0;
			lens[1] = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict_request(s_tuser[2:0], int'(s_tuser[3]), s_tdata, s_tuser[5:4]);
			if (m_tvalid && m_tready) begin
				got = mk(m_tuser, m_tdata[31:0], int'(m_tdata[38:32]), m_tdata[78:39],
					m_tlast);
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word: st=%0d val=%0d cnt=%0d mean=%0d last=%0b",
							got.status, got.value, got.count, got.mean, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want || m_tdata[79] !== 1'b0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp st=%0d val=%0d cnt=%0d mean=%0d last=%0b",
								want.status, want.value, want.count, want.mean, want.last,
								" | got st=%0d val=%0d cnt=%0d mean=%0d last=%0b",
								got.status, got.value, got.count, got.mean, got.last);
					end
				end
			end
		end
	end

endmodule

>>> bench/dual_list_sort_stat_engine_tb.sv
`timescale 1ns / 100ps
// Top of the dual list engine bench: clock, reset, request stimulus and verdict.
// Depends on dlss_pkg, dual_list_sort_stat_engine and dual_list_sort_stat_checker.
module dual_list_sort_stat_engine_tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] operand_value
	logic [5:0]  s_tuser;   // [2:0] req_type, [3] list_sel, [5:4] sort_order
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // [31:0] element_value, [38:32] element_count, [78:39] mean_q8
	logic [2:0]  m_tuser;   // [2:0] status
	logic        m_tlast;
	int          fail_count;
	int          pending;
	bit          long_hold;
	bit          hold_done;

	dual_list_sort_stat_engine dut (.*);
	dual_list_sort_stat_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// values that also hit for removes: a small pool, mixed with full-range ones
	logic signed [31:0] value_pool [8] = '{0, 1, -1, 32'h7FFFFFFF, 32'h80000000, 5, -5, 100};

	task automatic send_request(logic [2:0] req, logic sel, logic [31:0] v, logic [1:0] ord);
		int gap;
		gap = $urandom_range(0, 6);
		repeat (gap) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= {ord, sel, req};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		return $urandom_range(0, 1) ? value_pool[3'($urandom_range(0, 7))] : $urandom;
	endfunction

	// receiver: random stalls, plus one long hold-off while requests keep coming
	initial begin
		int wait_cycles;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_done = 1'b1;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (wait_cycles == 0) m_tready <= 1'b1;
			else begin
				m_tready <= 1'b0;
				repeat (wait_cycles - 1) @(negedge clk);
				@(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#200_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int r;
		int k;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		long_hold = 1'b0;
		hold_done = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty-list cases, extremes, every sort order, unused codes
		send_request(dlss_pkg::REQ_SHOW, 1'b0, 32'd0, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_MEAN, 1'b0, 32'd0, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_COUNT, 1'b1, 32'd0, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_REMOVE, 1'b0, 32'd7, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_APPEND, 1'b0, 32'h7FFFFFFF, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_APPEND, 1'b0, 32'h80000000, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_APPEND, 1'b0, 32'hFFFFFFFF, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_APPEND, 1'b0, 32'h7FFFFFFF, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_SHOW, 1'b0, 32'd0, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_SHOW, 1'b0, 32'd0, dlss_pkg::ORD_DESC);
		send_request(dlss_pkg::REQ_SHOW, 1'b0, 32'd0, dlss_pkg::ORD_INSERT);
		// undefined sort order behaves as insertion order
		send_request(dlss_pkg::REQ_SHOW, 1'b0, 32'hFFFFFFFF, 2'd3);
		send_request(dlss_pkg::REQ_MEAN, 1'b0, 32'd0, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_REMOVE, 1'b0, 32'h7FFFFFFF, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_REMOVE, 1'b0, 32'd12345, dlss_pkg::ORD_ASC);
		// unused request codes
		send_request(3'd5, 1'b1, 32'd1, dlss_pkg::ORD_ASC);
		send_request(3'd6, 1'b0, 32'd2, dlss_pkg::ORD_ASC);
		send_request(3'd7, 1'b1, 32'd3, 2'd3);
		// fill list B to capacity, then overflow, then take its mean
		for (int i = 0; i < 64; i++)
			send_request(dlss_pkg::REQ_APPEND, 1'b1, 32'h80000000 + i * 3, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_APPEND, 1'b1, 32'hDEADBEEF, dlss_pkg::ORD_ASC);
		send_request(dlss_pkg::REQ_MEAN, 1'b1, 32'd0, dlss_pkg::ORD_ASC);

		// long receiver hold-off while a stream of requests is offered
		long_hold = 1'b1;
		for (int i = 0; i < 10; i++)
			send_request(dlss_pkg::REQ_COUNT, 1'(i % 2), 32'd0, dlss_pkg::ORD_ASC);

		// random phase: removes use pooled values so that hits occur
		for (int i = 0; i < 186; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 1);
			if (r < 35)
				send_request(dlss_pkg::REQ_APPEND, 1'(k), pick_value(), 2'($urandom));
			else if (r < 60)
				send_request(dlss_pkg::REQ_REMOVE, 1'(k), pick_value(), 2'($urandom));
			else if (r < 75)
				send_request(dlss_pkg::REQ_SHOW, 1'(k), $urandom, 2'($urandom_range(0, 3)));
			else if (r < 85)
				send_request(dlss_pkg::REQ_COUNT, 1'(k), $urandom, 2'($urandom));
			else if (r < 95)
				send_request(dlss_pkg::REQ_MEAN, 1'(k), $urandom, 2'($urandom));
			else
				send_request(3'($urandom_range(5, 7)), 1'(k), $urandom, 2'($urandom));
		end

		wait (pending == 0);
		repeat (3000) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
